/* design/sbme_pkg.sv */
// ----------------------------------------------------------------------------
// sbme_pkg
// Types, constants and tables shared by the sequence-to-MIDI converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbme_pkg;

   localparam int DELAY_WIDTH_DEFAULT = 28;
   localparam int VLQ_BITS            = 28;
   localparam int DIVIDEND_BITS       = 26;
   localparam logic [DIVIDEND_BITS-1:0] USEC_PER_MINUTE = 26'd60000000;
   localparam int QUO_BITS            = 24;
   localparam int TEMPO_BITS          = 11;

   localparam logic [7:0] OP_REST      = 8'h00;
   localparam logic [7:0] OP_REPEAT_A  = 8'hA0;
   localparam logic [7:0] OP_REPEAT_E  = 8'hE0;
   localparam logic [7:0] OP_VARLEN_A  = 8'hA1;
   localparam logic [7:0] OP_VARLEN_E  = 8'hE1;
   localparam logic [7:0] OP_TEMPO     = 8'hFD;
   localparam logic [7:0] OP_INSTR     = 8'hFE;
   localparam logic [7:0] TEMPO_SPLIT  = 8'h3B;

   localparam logic [7:0] MIDI_PROGRAM = 8'hC0;
   localparam logic [7:0] MIDI_NOTE_ON = 8'h90;
   localparam logic [7:0] META_FF      = 8'hFF;
   localparam logic [7:0] META_EOT     = 8'h2F;
   localparam logic [7:0] META_TEMPO   = 8'h51;
   localparam logic [7:0] META_LEN3    = 8'h03;
   localparam logic [6:0] VELOCITY_RESET = 7'd100;

   typedef enum logic [3:0] {
      PH_IDLE, PH_REST1, PH_REST2, PH_VEL, PH_LEN1, PH_LEN2,
      PH_SKIP, PH_TEMPO, PH_INST
   } phase_type;

   typedef enum logic [1:0] {EV_NONE, EV_NOTE, EV_END, EV_TEMPO} ev_type;

   typedef enum logic [3:0] {
      SEL_DLY, SEL_LEN, SEL_PROG, SEL_INST, SEL_ZERO, SEL_ZERO_PC, SEL_NOTEON,
      SEL_NOTE, SEL_VEL, SEL_FF, SEL_EOT, SEL_TEMPO, SEL_LEN3,
      SEL_US2, SEL_US1, SEL_US0
   } sel_type;

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_type;

   typedef struct packed {
      sel_type    sel;
      logic [1:0] grp;
      logic       final_step;
   } script_type;

   typedef struct packed {
      logic       exec;
      logic       div_step;
      logic       note_done;
      logic       load;
      sel_type    sel;
      logic [1:0] grp;
      logic       to_ctl;
      logic       tend;
      logic       last;
   } cmd_type;

   typedef struct packed {
      ev_type     kind;
      logic [2:0] dly_groups;
      logic [2:0] len_groups;
      logic       need_pc;
      logic       div_last;
   } status_type;

   function automatic logic [7:0] preset_ticks(input logic [3:0] idx);
      logic [7:0] t;
      case (idx)
         4'd0:    t = 8'd12;
         4'd1:    t = 8'd24;
         4'd2:    t = 8'd36;
         4'd3:    t = 8'd48;
         4'd4:    t = 8'd72;
         4'd5:    t = 8'd96;
         4'd6:    t = 8'd144;
         4'd7:    t = 8'd168;
         4'd8:    t = 8'd192;
         4'd9:    t = 8'd24;
         4'd10:   t = 8'd36;
         4'd11:   t = 8'd48;
         4'd12:   t = 8'd72;
         4'd13:   t = 8'd96;
         4'd14:   t = 8'd144;
         default: t = 8'd168;
      endcase
      return t;
   endfunction

   // byte order of each emitted event; optional steps are skipped by the controller
   function automatic script_type script(input ev_type kind, input logic [3:0] step);
      script_type s;
      s = '{sel: SEL_ZERO, grp: 2'd0, final_step: 1'b0};
      case (kind)
         EV_NOTE: begin
            case (step)
               4'd0:    s = '{SEL_DLY, 2'd3, 1'b0};
               4'd1:    s = '{SEL_DLY, 2'd2, 1'b0};
               4'd2:    s = '{SEL_DLY, 2'd1, 1'b0};
               4'd3:    s = '{SEL_DLY, 2'd0, 1'b0};
               4'd4:    s = '{SEL_PROG, 2'd0, 1'b0};
               4'd5:    s = '{SEL_INST, 2'd0, 1'b0};
               4'd6:    s = '{SEL_ZERO_PC, 2'd0, 1'b0};
               4'd7:    s = '{SEL_NOTEON, 2'd0, 1'b0};
               4'd8:    s = '{SEL_NOTE, 2'd0, 1'b0};
               4'd9:    s = '{SEL_VEL, 2'd0, 1'b0};
               4'd10:   s = '{SEL_LEN, 2'd2, 1'b0};
               4'd11:   s = '{SEL_LEN, 2'd1, 1'b0};
               4'd12:   s = '{SEL_LEN, 2'd0, 1'b0};
               4'd13:   s = '{SEL_NOTE, 2'd0, 1'b0};
               default: s = '{SEL_ZERO, 2'd0, 1'b1};
            endcase
         end
         EV_END: begin
            case (step)
               4'd0:    s = '{SEL_ZERO, 2'd0, 1'b0};
               4'd1:    s = '{SEL_FF, 2'd0, 1'b0};
               4'd2:    s = '{SEL_EOT, 2'd0, 1'b0};
               default: s = '{SEL_ZERO, 2'd0, 1'b1};
            endcase
         end
         EV_TEMPO: begin
            case (step)
               4'd0:    s = '{SEL_ZERO, 2'd0, 1'b0};
               4'd1:    s = '{SEL_FF, 2'd0, 1'b0};
               4'd2:    s = '{SEL_TEMPO, 2'd0, 1'b0};
               4'd3:    s = '{SEL_LEN3, 2'd0, 1'b0};
               4'd4:    s = '{SEL_US2, 2'd0, 1'b0};
               4'd5:    s = '{SEL_US1, 2'd0, 1'b0};
               default: s = '{SEL_US0, 2'd0, 1'b1};
            endcase
         end
         default: s = '{SEL_ZERO, 2'd0, 1'b1};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

/* design/sbme_datapath.sv */
// ----------------------------------------------------------------------------
// sbme_datapath
// Command parser state, delay accumulator, tempo divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbme_datapath #(
   parameter int DELAY_WIDTH = sbme_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           req_seq_byte,
   input  wire logic                 req_track_start,
   input  wire logic [3:0]           req_channel,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_format_version,
   input  wire sbme_pkg::cmd_type    cmd,
   output sbme_pkg::status_type      status,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_to_control,
   output logic                      rsp_track_end,
   output logic                      rsp_last
);

   localparam logic [DELAY_WIDTH-1:0] DELAY_CAP = {DELAY_WIDTH{1'b1}};

   sbme_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  hop_ff, hop_in;
   logic [DELAY_WIDTH-1:0] dly_ff, dly_in;
   logic [15:0] len_ff, len_in;
   logic [6:0]  note_ff, note_in;
   logic [6:0]  vel_ff, vel_in;
   logic [7:0]  inst_ff, inst_in;
   logic        pc_ff, pc_in;
   logic        var_ff, var_in;
   logic        fin_ff, fin_in;
   logic [3:0]  ch_ff, ch_in;
   logic        fmt_ff;

   logic [sbme_pkg::TEMPO_BITS-1:0] div_ff, div_in;
   logic [sbme_pkg::TEMPO_BITS-1:0] rem_ff, rem_in;
   logic [sbme_pkg::QUO_BITS-1:0]   quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [7:0]  out_byte_ff, out_byte_in;
   logic        to_ctl_ff, tend_ff, last_ff;

   // effective state after an optional track restart
   sbme_pkg::phase_type e_phase;
   logic [7:0]  e_hop;
   logic [DELAY_WIDTH-1:0] e_dly;
   logic [15:0] e_len;
   logic [6:0]  e_vel;
   logic [7:0]  e_inst;
   logic        e_pc, e_var, e_fin;
   logic [3:0]  e_ch;

   sbme_pkg::ev_type kind;
   logic [15:0] amt;
   logic        dly_clear;
   logic [15:0] long_val;
   logic [15:0] short_val;
   logic [15:0] preset_val;
   logic [7:0]  b;
   logic [DELAY_WIDTH:0] dly_sum;
   logic [sbme_pkg::TEMPO_BITS-1:0] tempo;
   logic [sbme_pkg::TEMPO_BITS:0]   trial;
   logic [sbme_pkg::VLQ_BITS-1:0]   dly_ext;
   logic [20:0] len_ext;

   assign b          = req_seq_byte;
   // long operand: current byte is the high byte, held byte gives 2*(b1-0x80)
   assign long_val   = {b, 8'h00} + {8'd0, e_hop[6:0], 1'b0};
   assign short_val  = {7'd0, b, 1'b0};
   assign preset_val = {7'd0, sbme_pkg::preset_ticks(b[3:0]), 1'b0};

   always_comb begin
      if (b < sbme_pkg::TEMPO_SPLIT) begin
         tempo = 11'd405 - ({3'd0, b} * 11'd5);
      end else begin
         tempo = 11'd120 + ({3'd0, b - sbme_pkg::TEMPO_SPLIT} * 11'd5);
      end
   end

   always_comb begin
      e_phase = req_track_start ? sbme_pkg::PH_IDLE : phase_ff;
      e_hop   = req_track_start ? 8'd0 : hop_ff;
      e_dly   = req_track_start ? '0 : dly_ff;
      e_len   = req_track_start ? 16'd0 : len_ff;
      e_vel   = req_track_start ? sbme_pkg::VELOCITY_RESET : vel_ff;
      e_inst  = req_track_start ? 8'd0 : inst_ff;
      e_pc    = req_track_start ? 1'b1 : pc_ff;
      e_var   = req_track_start ? 1'b1 : var_ff;
      e_fin   = req_track_start ? 1'b0 : fin_ff;
      e_ch    = req_track_start ? req_channel : ch_ff;

      phase_in = phase_ff;
      hop_in   = hop_ff;
      len_in   = len_ff;
      note_in  = note_ff;
      vel_in   = vel_ff;
      inst_in  = inst_ff;
      pc_in    = pc_ff;
      var_in   = var_ff;
      fin_in   = fin_ff;
      ch_in    = ch_ff;
      dly_in   = dly_ff;
      kind     = sbme_pkg::EV_NONE;
      amt      = 16'd0;
      dly_clear = 1'b0;

      if (!e_fin) begin
         case (e_phase)
            sbme_pkg::PH_REST1: begin
               if (!b[7]) begin
                  amt = short_val;
               end
            end
            sbme_pkg::PH_REST2: amt = long_val;
            sbme_pkg::PH_VEL: begin
               if (!e_var) begin
                  kind = sbme_pkg::EV_NOTE;
               end
            end
            sbme_pkg::PH_LEN1: begin
               if (!b[7]) begin
                  kind = sbme_pkg::EV_NOTE;
               end
            end
            sbme_pkg::PH_LEN2: kind = sbme_pkg::EV_NOTE;
            sbme_pkg::PH_SKIP: ;
            sbme_pkg::PH_TEMPO: kind = sbme_pkg::EV_TEMPO;
            sbme_pkg::PH_INST: ;
            default: begin
               if (b != sbme_pkg::OP_REST && !b[7]) begin
                  if (!fmt_ff && !e_var) begin
                     kind = sbme_pkg::EV_NOTE;
                  end
               end else if (b[7:4] == 4'h8) begin
                  amt = preset_val;
               end else if (b == sbme_pkg::OP_REPEAT_A || b == sbme_pkg::OP_REPEAT_E) begin
                  kind = sbme_pkg::EV_NOTE;
               end else if (b == 8'hF1 || b == 8'hF2 || b == 8'hF8 || b == 8'hFF) begin
                  kind = sbme_pkg::EV_END;
                  dly_clear = 1'b1;
               end
            end
         endcase
      end

      if (cmd.exec) begin
         phase_in = e_phase;
         hop_in   = e_hop;
         len_in   = e_len;
         vel_in   = e_vel;
         inst_in  = e_inst;
         pc_in    = e_pc;
         var_in   = e_var;
         fin_in   = e_fin;
         ch_in    = e_ch;
         if (!e_fin) begin
            phase_in = sbme_pkg::PH_IDLE;
            case (e_phase)
               sbme_pkg::PH_REST1: begin
                  if (b[7]) begin
                     hop_in   = b;
                     phase_in = sbme_pkg::PH_REST2;
                  end
               end
               sbme_pkg::PH_VEL: begin
                  vel_in = b[7:1];
                  if (e_var) begin
                     phase_in = sbme_pkg::PH_LEN1;
                  end
               end
               sbme_pkg::PH_LEN1: begin
                  if (b[7]) begin
                     hop_in   = b;
                     phase_in = sbme_pkg::PH_LEN2;
                  end else begin
                     len_in = short_val;
                  end
               end
               sbme_pkg::PH_LEN2: len_in = long_val;
               sbme_pkg::PH_INST: begin
                  if (b != e_inst) begin
                     inst_in = b;
                     pc_in   = 1'b1;
                  end
               end
               sbme_pkg::PH_IDLE: begin
                  if (b == sbme_pkg::OP_REST) begin
                     phase_in = sbme_pkg::PH_REST1;
                  end else if (!b[7]) begin
                     note_in = b[6:0];
                     if (fmt_ff) begin
                        phase_in = sbme_pkg::PH_VEL;
                     end else if (e_var) begin
                        phase_in = sbme_pkg::PH_LEN1;
                     end
                  end else if (b[7:4] == 4'h9) begin
                     var_in = 1'b0;
                     len_in = preset_val;
                  end else if (b == sbme_pkg::OP_VARLEN_A || b == sbme_pkg::OP_VARLEN_E) begin
                     var_in = 1'b1;
                  end else if (b == 8'hE4 || b == 8'hE9 || (b >= 8'hEB && b <= 8'hF0)
                               || b == 8'hF7 || b == 8'hF9 || b == 8'hFC) begin
                     phase_in = sbme_pkg::PH_SKIP;
                  end else if (kind == sbme_pkg::EV_END) begin
                     fin_in = 1'b1;
                  end else if (b == sbme_pkg::OP_TEMPO) begin
                     phase_in = sbme_pkg::PH_TEMPO;
                  end else if (b == sbme_pkg::OP_INSTR) begin
                     phase_in = sbme_pkg::PH_INST;
                  end
               end
               default: ;
            endcase
         end
         if (dly_clear) begin
            dly_in = '0;
         end else if (dly_sum[DELAY_WIDTH]) begin
            dly_in = DELAY_CAP;
         end else begin
            dly_in = dly_sum[DELAY_WIDTH-1:0];
         end
      end

      // delay and program change are consumed once the note bytes are out
      if (cmd.note_done) begin
         dly_in = '0;
         pc_in  = 1'b0;
      end
   end

   assign dly_sum = {1'b0, e_dly} + (DELAY_WIDTH+1)'(amt);

   // restoring divider, one quotient bit per cycle
   always_comb begin
      div_in = div_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, sbme_pkg::USEC_PER_MINUTE[cnt_ff]};
      if (cmd.exec && kind == sbme_pkg::EV_TEMPO) begin
         div_in = tempo;
         rem_in = '0;
         quo_in = '0;
         cnt_in = 5'(sbme_pkg::DIVIDEND_BITS - 1);
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = sbme_pkg::TEMPO_BITS'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[sbme_pkg::QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[sbme_pkg::TEMPO_BITS-1:0];
            quo_in = {quo_ff[sbme_pkg::QUO_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
      end
   end

   assign dly_ext = sbme_pkg::VLQ_BITS'(dly_ff);
   assign len_ext = {5'd0, len_ff};

   always_comb begin
      status.kind = kind;
      status.need_pc = pc_ff;
      status.div_last = (cnt_ff == 5'd0);
      if (dly_ext[27:21] != 7'd0) begin
         status.dly_groups = 3'd4;
      end else if (dly_ext[20:14] != 7'd0) begin
         status.dly_groups = 3'd3;
      end else if (dly_ext[13:7] != 7'd0) begin
         status.dly_groups = 3'd2;
      end else begin
         status.dly_groups = 3'd1;
      end
      if (len_ext[20:14] != 7'd0) begin
         status.len_groups = 3'd3;
      end else if (len_ext[13:7] != 7'd0) begin
         status.len_groups = 3'd2;
      end else begin
         status.len_groups = 3'd1;
      end
   end

   always_comb begin
      case (cmd.sel)
         sbme_pkg::SEL_DLY: begin
            case (cmd.grp)
               2'd0:    out_byte_in = {1'b0, dly_ext[6:0]};
               2'd1:    out_byte_in = {1'b1, dly_ext[13:7]};
               2'd2:    out_byte_in = {1'b1, dly_ext[20:14]};
               default: out_byte_in = {1'b1, dly_ext[27:21]};
            endcase
         end
         sbme_pkg::SEL_LEN: begin
            case (cmd.grp)
               2'd0:    out_byte_in = {1'b0, len_ext[6:0]};
               2'd1:    out_byte_in = {1'b1, len_ext[13:7]};
               default: out_byte_in = {1'b1, len_ext[20:14]};
            endcase
         end
         sbme_pkg::SEL_PROG:    out_byte_in = sbme_pkg::MIDI_PROGRAM | {4'd0, ch_ff};
         sbme_pkg::SEL_INST:    out_byte_in = inst_ff;
         sbme_pkg::SEL_NOTEON:  out_byte_in = sbme_pkg::MIDI_NOTE_ON | {4'd0, ch_ff};
         sbme_pkg::SEL_NOTE:    out_byte_in = {1'b0, note_ff};
         sbme_pkg::SEL_VEL:     out_byte_in = {1'b0, vel_ff};
         sbme_pkg::SEL_FF:      out_byte_in = sbme_pkg::META_FF;
         sbme_pkg::SEL_EOT:     out_byte_in = sbme_pkg::META_EOT;
         sbme_pkg::SEL_TEMPO:   out_byte_in = sbme_pkg::META_TEMPO;
         sbme_pkg::SEL_LEN3:    out_byte_in = sbme_pkg::META_LEN3;
         sbme_pkg::SEL_US2:     out_byte_in = quo_ff[23:16];
         sbme_pkg::SEL_US1:     out_byte_in = quo_ff[15:8];
         sbme_pkg::SEL_US0:     out_byte_in = quo_ff[7:0];
         default:               out_byte_in = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sbme_pkg::PH_IDLE;
         hop_ff   <= 8'd0;
         dly_ff   <= '0;
         len_ff   <= 16'd0;
         note_ff  <= 7'd0;
         vel_ff   <= sbme_pkg::VELOCITY_RESET;
         inst_ff  <= 8'd0;
         pc_ff    <= 1'b1;
         var_ff   <= 1'b1;
         fin_ff   <= 1'b0;
         ch_ff    <= 4'd0;
         fmt_ff   <= 1'b1;
         cnt_ff   <= 5'd0;
      end else begin
         phase_ff <= phase_in;
         hop_ff   <= hop_in;
         dly_ff   <= dly_in;
         len_ff   <= len_in;
         note_ff  <= note_in;
         vel_ff   <= vel_in;
         inst_ff  <= inst_in;
         pc_ff    <= pc_in;
         var_ff   <= var_in;
         fin_ff   <= fin_in;
         ch_ff    <= ch_in;
         cnt_ff   <= cnt_in;
         if (csr_valid) begin
            fmt_ff <= csr_format_version;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load) begin
         out_byte_ff <= out_byte_in;
         to_ctl_ff   <= cmd.to_ctl;
         tend_ff     <= cmd.tend;
         last_ff     <= cmd.last;
      end
   end

   assign rsp_out_byte   = out_byte_ff;
   assign rsp_to_control = to_ctl_ff;
   assign rsp_track_end  = tend_ff;
   assign rsp_last       = last_ff;

endmodule

`default_nettype wire

/* design/sbme_ctrl.sv */
// ----------------------------------------------------------------------------
// sbme_ctrl
// Sequencer: takes bytes, runs the tempo divider and walks the byte scripts.
// ----------------------------------------------------------------------------
`default_nettype none

module sbme_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire sbme_pkg::status_type  status,
   output sbme_pkg::cmd_type          cmd
);

   sbme_pkg::state_type state_ff, state_in;
   sbme_pkg::ev_type    kind_ff, kind_in;
   logic [3:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sbme_pkg::script_type cur;
   logic                skip;
   logic                can_load;

   assign cur      = sbme_pkg::script(kind_ff, step_ff);
   assign can_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cur.sel)
         sbme_pkg::SEL_DLY:     skip = ({1'b0, cur.grp} >= status.dly_groups);
         sbme_pkg::SEL_LEN:     skip = ({1'b0, cur.grp} >= status.len_groups);
         sbme_pkg::SEL_PROG,
         sbme_pkg::SEL_INST,
         sbme_pkg::SEL_ZERO_PC,
         sbme_pkg::SEL_NOTEON:  skip = !status.need_pc;
         default:               skip = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.sel   = cur.sel;
      cmd.grp   = cur.grp;
      cmd.to_ctl = (kind_ff == sbme_pkg::EV_TEMPO);
      cmd.tend  = (kind_ff == sbme_pkg::EV_END);
      cmd.last  = cur.final_step;
      case (state_ff)
         sbme_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               kind_in  = status.kind;
               step_in  = 4'd0;
               case (status.kind)
                  sbme_pkg::EV_TEMPO: state_in = sbme_pkg::ST_DIV;
                  sbme_pkg::EV_NOTE,
                  sbme_pkg::EV_END:   state_in = sbme_pkg::ST_EMIT;
                  default:            state_in = sbme_pkg::ST_IDLE;
               endcase
            end
         end
         sbme_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = sbme_pkg::ST_EMIT;
            end
         end
         sbme_pkg::ST_EMIT: begin
            if (skip) begin
               step_in = step_ff + 4'd1;
            end else if (can_load) begin
               cmd.load = 1'b1;
               step_in  = step_ff + 4'd1;
               if (cur.final_step) begin
                  cmd.note_done = (kind_ff == sbme_pkg::EV_NOTE);
                  state_in = sbme_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sbme_pkg::ST_IDLE;
      endcase
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbme_pkg::ST_IDLE;
         kind_ff      <= sbme_pkg::EV_NONE;
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* design/sequence_bytes_to_midi_events.sv */
// Flow: a byte with no output is taken without leaving idle; a note walks its
// script step by step (15 steps, skipped ones included) after the transfer.
// Tempo bytes run the divider to completion before their 7 output bytes.
// Throughput: one input byte per cycle when nothing is emitted, else gated by output.
// Synchronous active-high reset; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
// sequence_bytes_to_midi_events
// Assembles sound-driver sequence commands into MIDI track bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_bytes_to_midi_events #(
   parameter int DELAY_WIDTH = sbme_pkg::DELAY_WIDTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_seq_byte,
   input  wire logic       req_track_start,
   input  wire logic [3:0] req_channel,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_to_control,
   output logic            rsp_track_end,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_format_version
);

   sbme_pkg::cmd_type    cmd;
   sbme_pkg::status_type status;

   assign csr_ready = 1'b1;

   sbme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sbme_datapath #(.DELAY_WIDTH(DELAY_WIDTH)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_seq_byte       (req_seq_byte),
      .req_track_start    (req_track_start),
      .req_channel        (req_channel),
      .csr_valid          (csr_valid),
      .csr_format_version (csr_format_version),
      .cmd                (cmd),
      .status             (status),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_to_control     (rsp_to_control),
      .rsp_track_end      (rsp_track_end),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

/* design/sbme_checker.sv */
// ----------------------------------------------------------------------------
// sbme_checker
// Port-level checks for the sequence-to-MIDI converter.
// ----------------------------------------------------------------------------
`default_nettype none

module sbme_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_to_control,
   input wire logic       rsp_track_end,
   input wire logic       rsp_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("result changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_streams: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_track_end && rsp_to_control))
      else $error("end of track on control stream");

   // while an event is still being sent no new byte is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input taken mid-event");

endmodule

bind sequence_bytes_to_midi_events sbme_checker u_sbme_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_to_control (rsp_to_control),
   .rsp_track_end  (rsp_track_end),
   .rsp_last       (rsp_last)
);

`default_nettype wire
